### rtl/fir_decimator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimating FIR core
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef FIR_DECIMATOR_CORE_ASSERT_SVH
`define FIR_DECIMATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Types and constants shared by the decimating FIR core and its units.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int INDEX_W     = 6;
   localparam int RATIO_W     = 5;
   localparam int TAPS_W      = 7;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   // Item kinds carried on req_tuser.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS  = 1'b1;

   // Rounding shift for Q.15 to integer.
   localparam int ROUND_SHIFT = 15;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } fdc_state_type;

   typedef struct packed {
      logic clear;       // zero the accumulator before a new output
      logic data_valid;  // memory read data holds a sample and a coefficient
      logic data_last;   // that pair is the last one of this output
      logic ack;         // the held result has been taken
   } mac_ctl_type;

   typedef struct packed {
      logic                       result_valid;
      logic signed [SAMPLE_W-1:0] result;
   } mac_sts_type;

endpackage

`default_nettype wire

### rtl/fdc_ram.sv
// ----------------------------------------------------------------------------
// fdc_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### rtl/fdc_mac.sv
// ----------------------------------------------------------------------------
// fdc_mac
// Multiply-accumulate unit with rounding and saturation of the finished sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fdc_mac #(
   parameter int ACC_W = 39
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire fdc_pkg::mac_ctl_type                  ctl,
   input  wire logic signed [fdc_pkg::SAMPLE_W-1:0]   sample,
   input  wire logic signed [fdc_pkg::COEF_W-1:0]     coef,
   output fdc_pkg::mac_sts_type                       sts
);

   import fdc_pkg::*;

   localparam int QW = ACC_W - ROUND_SHIFT;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic                     prod_last_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     fin_ff;
   logic signed [SAMPLE_W-1:0] result_ff;
   logic signed [SAMPLE_W-1:0] result_in;
   logic                     result_valid_ff;

   logic signed [ACC_W-1:0]  rounded;
   logic signed [QW-1:0]     quot;
   logic [QW-SAMPLE_W:0]     quot_hi;

   always_ff @(posedge clock) begin
      if (ctl.data_valid) begin
         prod_ff <= PROD_W'(sample) * PROD_W'(coef);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff   <= 1'b0;
         prod_last_ff    <= 1'b0;
         fin_ff          <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.data_valid;
         prod_last_ff  <= ctl.data_valid & ctl.data_last;
         fin_ff        <= prod_valid_ff & prod_last_ff;
         if (fin_ff) begin
            result_valid_ff <= 1'b1;
         end else if (ctl.ack) begin
            result_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // Round to nearest with halves toward plus infinity, then clip to 16 bits.
   always_comb begin
      rounded = acc_ff + ACC_W'(1 << (ROUND_SHIFT - 1));
      quot    = QW'(rounded >>> ROUND_SHIFT);
      quot_hi = quot[QW-1:SAMPLE_W-1];
      if (quot_hi == '0 || quot_hi == '1) begin
         result_in = quot[SAMPLE_W-1:0];
      end else if (quot[QW-1]) begin
         result_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ff) begin
         result_ff <= result_in;
      end
   end

   assign sts.result_valid = result_valid_ff;
   assign sts.result       = result_ff;

endmodule

`default_nettype wire

### rtl/fir_decimator_core.sv
// ----------------------------------------------------------------------------
// fir_decimator_core
// Decimating FIR filter with sample history and coefficients held in RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake              Payload
//   req       in    req_tvalid/req_tready  tdata: sample, coef_index, coef_value
//                                          tuser: kind
//   rsp       out   rsp_tvalid/rsp_tready  tdata: filtered
//   csr       in    csr_we                 csr_index, csr_wdata
//
// A coefficient write or a sample that completes no output leaves the core idle,
// ready for the next item. A sample that completes an output holds the core for
// one history read and one coefficient read per tap through the single read port
// of each RAM, then the multiply, accumulate and rounding stages.
// After reset a clearing pass zeroes every address of both RAMs; no item is
// accepted during it. The output register lets the next item be accepted
// while a result waits; a new result stalls until that transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_decimator_core #(
   parameter int MAX_TAPS  = 64,
   parameter int MAX_RATIO = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] sample, [21:16] coef_index, [37:22] coef_value, [39:38] zero
   input  wire logic [fdc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] kind
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] filtered
   output logic      [fdc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [fdc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [fdc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import fdc_pkg::*;

   `include "fir_decimator_core_assert.svh"

   localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int NW    = $clog2(MAX_TAPS + 1);
   localparam int PW    = (MAX_RATIO > 1) ? $clog2(MAX_RATIO + 1) : 1;
   localparam int ACC_W = PROD_W + AW + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
   localparam logic [AW:0]   TAPS_X    = (AW+1)'(MAX_TAPS);

   fdc_state_type state_ff, state_in;

   logic [RATIO_W-1:0] ratio_ff;
   logic [TAPS_W-1:0]  taps_ff;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [PW-1:0]      phase_ff, phase_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      k_ff, k_in;
   logic               rd_valid_ff, rd_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic               rsp_load;

   logic [PW-1:0]      eff_ratio;
   logic [NW-1:0]      eff_taps;
   logic [AW-1:0]      wp_next;
   logic [PW-1:0]      phase_next;
   logic [AW:0]        start_sum;
   logic [AW:0]        start_wrap;
   logic [AW-1:0]      start_pos;
   logic               issue, issue_last;
   logic               accept;

   logic [SAMPLE_W-1:0] in_sample;
   logic [INDEX_W-1:0]  in_index;
   logic [COEF_W-1:0]   in_coef;
   logic                in_kind;

   logic               hist_we, coef_we;
   logic [AW-1:0]      hist_waddr, coef_waddr;
   logic [SAMPLE_W-1:0] hist_wdata;
   logic [COEF_W-1:0]   coef_wdata;
   logic [SAMPLE_W-1:0] hist_rdata;
   logic [COEF_W-1:0]   coef_rdata;

   mac_ctl_type mac_ctl;
   mac_sts_type mac_sts;

   assign in_sample = req_tdata[15:0];
   assign in_index  = req_tdata[21:16];
   assign in_coef   = req_tdata[37:22];
   assign in_kind   = req_tuser;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Out-of-range register values act as the nearest legal value.
   always_comb begin
      if (ratio_ff == '0) begin
         eff_ratio = PW'(1);
      end else if (32'(ratio_ff) > MAX_RATIO) begin
         eff_ratio = PW'(MAX_RATIO);
      end else begin
         eff_ratio = PW'(ratio_ff);
      end
      if (taps_ff == '0) begin
         eff_taps = NW'(1);
      end else if (32'(taps_ff) > MAX_TAPS) begin
         eff_taps = NW'(MAX_TAPS);
      end else begin
         eff_taps = NW'(taps_ff);
      end
   end

   // Oldest used slot is the advanced write pointer minus the tap count.
   always_comb begin
      wp_next    = (wp_ff == LAST_ADDR) ? '0 : wp_ff + AW'(1);
      phase_next = phase_ff + PW'(1);
      start_sum  = {1'b0, wp_next} + TAPS_X - (AW+1)'(eff_taps);
      start_wrap = start_sum - TAPS_X;
      start_pos  = (start_sum >= TAPS_X) ? start_wrap[AW-1:0] : start_sum[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ratio_ff     <= RATIO_W'(1);
         taps_ff      <= TAPS_W'(64);
         wp_ff        <= '0;
         phase_ff     <= '0;
         clr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rd_valid_ff  <= issue;
         rd_last_ff   <= issue_last;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RATIO: ratio_ff <= csr_wdata[RATIO_W-1:0];
               CSR_TAPS:  taps_ff  <= csr_wdata[TAPS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      k_ff   <= k_in;
      if (rsp_load) begin
         rsp_data_ff <= mac_sts.result;
      end
   end

   always_comb begin
      state_in           = state_ff;
      wp_in              = wp_ff;
      phase_in           = phase_ff;
      clr_in             = clr_ff;
      pos_in             = pos_ff;
      k_in               = k_ff;
      issue              = 1'b0;
      issue_last         = 1'b0;
      rsp_load           = 1'b0;
      mac_ctl.clear      = 1'b0;
      mac_ctl.ack        = 1'b0;
      mac_ctl.data_valid = rd_valid_ff;
      mac_ctl.data_last  = rd_last_ff;
      rsp_valid_in       = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && in_kind == KIND_SAMPLE) begin
               wp_in = wp_next;
               if (phase_next >= eff_ratio) begin
                  phase_in      = '0;
                  pos_in        = start_pos;
                  k_in          = '0;
                  mac_ctl.clear = 1'b1;
                  state_in      = ST_RUN;
               end else begin
                  phase_in = phase_next;
               end
            end
         end
         ST_RUN: begin
            issue  = 1'b1;
            pos_in = (pos_ff == LAST_ADDR) ? '0 : pos_ff + AW'(1);
            k_in   = k_ff + AW'(1);
            if (({1'b0, k_ff} + (AW+1)'(1)) == (AW+1)'(eff_taps)) begin
               issue_last = 1'b1;
               state_in   = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_sts.result_valid && (!rsp_valid_ff || rsp_tready)) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               mac_ctl.ack  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // The clearing pass owns both write ports until it finishes.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         hist_we    = 1'b1;
         hist_waddr = clr_ff;
         hist_wdata = '0;
         coef_we    = 1'b1;
         coef_waddr = clr_ff;
         coef_wdata = '0;
      end else begin
         hist_we    = accept && (in_kind == KIND_SAMPLE);
         hist_waddr = wp_ff;
         hist_wdata = in_sample;
         coef_we    = accept && (in_kind == KIND_COEF) && (32'(in_index) < MAX_TAPS);
         coef_waddr = AW'(in_index);
         coef_wdata = in_coef;
      end
   end

   fdc_ram #(
      .DEPTH (MAX_TAPS),
      .AW    (AW),
      .DW    (SAMPLE_W)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .re    (issue),
      .raddr (pos_ff),
      .rdata (hist_rdata)
   );

   fdc_ram #(
      .DEPTH (MAX_TAPS),
      .AW    (AW),
      .DW    (COEF_W)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .re    (issue),
      .raddr (k_ff),
      .rdata (coef_rdata)
   );

   fdc_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (hist_rdata),
      .coef   (coef_rdata),
      .sts    (mac_sts)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A finished result is always handed over before new items are taken.
   `FDC_ASSERT_SAME(a_idle_no_result, clock, reset, state_ff == ST_IDLE,
      !mac_sts.result_valid, "result pending while idle")
   // Read data only returns for reads issued by the tap sweep.
   `FDC_ASSERT_SAME(a_read_in_sweep, clock, reset, rd_valid_ff,
      state_ff == ST_RUN || state_ff == ST_WAIT, "stray memory read data")
   // The tap sweep never runs past the configured tap count.
   `FDC_ASSERT_SAME(a_tap_bound, clock, reset, issue,
      ({1'b0, k_ff} + (AW+1)'(1)) <= (AW+1)'(eff_taps), "tap index beyond tap count")
   // The write pointer stays within the history store.
   `FDC_ASSERT_SAME(a_wp_range, clock, reset, 1'b1, wp_ff <= LAST_ADDR,
      "write pointer out of range")
   // Handing a result over frees the unit and returns to idle.
   `FDC_ASSERT_NEXT(a_load_idle, clock, reset, rsp_load,
      rsp_valid_ff && state_ff == ST_IDLE, "result transfer did not complete the output")

endmodule

`default_nettype wire
